/* rtl/prf_pkg.sv */
package prf_pkg;

	// Field widths.
	localparam int SCORE_W  = 24;
	localparam int INC_W    = 23;
	localparam int FREQ_W   = 17;
	localparam int INDEX_W  = 10;
	localparam int RANK_W   = 23;
	localparam int CFG_IX_W = 2;

	// Shared divider geometry: quotient shift register, remainder and step count.
	localparam int DIV_Q_W  = 26;
	localparam int DIV_R_W  = 24;
	localparam int STEP_W   = 5;
	localparam int PROD_W   = FREQ_W + DIV_R_W;

	localparam int TABLE_DEPTH_DEFAULT = 1024;

	localparam logic [FREQ_W-1:0] FREQ_ONE = 17'd65536;
	localparam logic [RANK_W-1:0] RANK_MAX = 23'd6553600;

	// Step counts: the interval index has up to 26 bits, the rank 23 bits.
	localparam logic [STEP_W-1:0] DIV1_STEPS = 5'd26;
	localparam logic [STEP_W-1:0] DIV2_STEPS = 5'd23;

	// Register values after reset.
	localparam logic signed [SCORE_W-1:0] MIN_SCORE_RESET = 24'sd0;
	localparam logic signed [SCORE_W-1:0] MAX_SCORE_RESET = 24'sd10240;
	localparam logic [INC_W-1:0]          INC_RESET       = 23'd256;

	// Configuration register indexes.
	localparam logic [CFG_IX_W-1:0] CFG_MIN_SCORE = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_MAX_SCORE = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_SCORE_INC = 2'd2;

	// Operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Query sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV1,
		ST_RD_HI,
		ST_RD_LO,
		ST_CAP,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_SCALE,
		ST_DIV2,
		ST_DONE
	} q_state_t;

	// Divider command and status.
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic last;
	} div_stat_t;

endpackage

/* rtl/prf_divider.sv */
module prf_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  prf_pkg::div_cmd_t              cmd,
	input  logic [prf_pkg::DIV_R_W-1:0]    init_rem,
	input  logic [prf_pkg::DIV_Q_W-1:0]    init_low,
	input  logic [prf_pkg::DIV_R_W-1:0]    divisor,
	output prf_pkg::div_stat_t             stat,
	output logic [prf_pkg::DIV_Q_W-1:0]    quot,
	output logic [prf_pkg::DIV_R_W-1:0]    rem
);
	import prf_pkg::*;

	logic [DIV_R_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] low_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;

	logic [DIV_R_W:0]   trial;
	logic               ge;
	logic [DIV_R_W:0]   diff;
	logic [DIV_R_W-1:0] rem_nxt;

	// One restoring step: bring down the next bit, subtract when it fits.
	always_comb begin
		trial   = {rem_q, low_q[DIV_Q_W-1]};
		ge      = trial >= {1'b0, divisor};
		diff    = trial - {1'b0, divisor};
		rem_nxt = ge ? diff[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= init_rem;
			low_q <= init_low;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			low_q <= {low_q[DIV_Q_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.last = busy_q && (cnt_q == STEP_W'(1));
	assign quot      = low_q;
	assign rem       = rem_q;

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with zero step count");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q)
		else $error("divider did not start");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		stat.last && !cmd.start |=> !busy_q)
		else $error("divider kept running after its last step");

endmodule

/* rtl/prf_table.sv */
module prf_table #(
	parameter int TABLE_DEPTH = prf_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load_en,
	input  logic [prf_pkg::INDEX_W-1:0]      entry_index,
	input  logic [prf_pkg::FREQ_W-1:0]       freq_value,
	input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
	output logic [prf_pkg::FREQ_W-1:0]       rd_data
);
	import prf_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

	logic [FREQ_W-1:0] mem [TABLE_DEPTH];
	logic [FREQ_W-1:0] running_sum_q;
	logic [FREQ_W-1:0] rd_data_q;

	logic [FREQ_W-1:0] base;
	logic [FREQ_W:0]   sum_raw;
	logic [FREQ_W-1:0] sum_sat;
	logic [EXT_W-1:0]  idx_ext;
	logic              in_range;

	// Running sum restarts at index zero and saturates at one.
	always_comb begin
		base     = (entry_index == '0) ? '0 : running_sum_q;
		sum_raw  = {1'b0, base} + {1'b0, freq_value};
		sum_sat  = (sum_raw > {1'b0, FREQ_ONE}) ? FREQ_ONE : sum_raw[FREQ_W-1:0];
		idx_ext  = EXT_W'(entry_index);
		in_range = 32'(entry_index) < 32'(TABLE_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (load_en) begin
			running_sum_q <= sum_sat;
		end
	end

	// Cumulative table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (load_en && in_range) begin
			mem[idx_ext[IDX_W-1:0]] <= sum_sat;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/percentile_rank_from_frequencies.sv */
// Loads take effect at the accepting edge, give no result and leave busy low.
// A query runs on one serial divider, one bit a cycle, used twice (26 steps for the interval
// index, 23 for the rank), and one shared 17x24 multiplier. The result strobe cannot be held off.
// Done follows the second division of a query, or comes straight after prep for a rank of 0 or 100.
// A new query is accepted the cycle after done; queries do not overlap.
// Reset clears the sequencer, running sum and configuration registers; table entries are undefined until loaded.
module percentile_rank_from_frequencies #(
	parameter int TABLE_DEPTH = prf_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [prf_pkg::INDEX_W-1:0]         entry_index,
	input  logic [prf_pkg::FREQ_W-1:0]          freq_value,
	input  logic signed [prf_pkg::SCORE_W-1:0]  query_score,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prf_pkg::CFG_IX_W-1:0]        cfg_index,
	input  logic [prf_pkg::SCORE_W-1:0]         cfg_data,
	output logic                                done,
	output logic [prf_pkg::RANK_W-1:0]          percentile_rank
);
	import prf_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	q_state_t state_q, state_nxt;

	// Configuration registers.
	logic signed [SCORE_W-1:0] min_score_q;
	logic signed [SCORE_W-1:0] max_score_q;
	logic [INC_W-1:0]          score_inc_q;

	// Query datapath registers.
	logic signed [SCORE_W-1:0] x_q;
	logic [RANK_W-1:0]         rank_q;
	logic                      use_div_q;
	logic                      clamp_q;
	logic [DIV_R_W-1:0]        r_q;
	logic [FREQ_W-1:0]         hi_q;
	logic [FREQ_W-1:0]         lo_q;
	logic [PROD_W-1:0]         prod_q;
	logic [PROD_W-1:0]         acc_q;
	logic [PROD_W-1:0]         num_q;

	logic                      accept;
	logic                      load_en;
	logic [INC_W-1:0]          inc_eff;
	logic [DIV_R_W-1:0]        two_inc;
	logic signed [26:0]        x_ext;
	logic signed [26:0]        d_val;
	logic signed [26:0]        two_x;
	logic signed [26:0]        hundred_lim;
	logic                      below;
	logic                      above;
	logic                      clamp_c;
	logic [IDX_W-1:0]          rd_addr;
	logic [FREQ_W-1:0]         rd_data;
	logic [FREQ_W-1:0]         mul_a;
	logic [DIV_R_W-1:0]        mul_b;
	logic [PROD_W-1:0]         mul_p;
	logic [46:0]               scaled;

	div_cmd_t                  div_cmd;
	div_stat_t                 div_stat;
	logic [DIV_R_W-1:0]        div_init_rem;
	logic [DIV_Q_W-1:0]        div_init_low;
	logic [DIV_Q_W-1:0]        div_quot;
	logic [DIV_R_W-1:0]        div_rem;

	assign accept    = start && !busy;
	assign load_en   = accept && (operation == OP_LOAD);
	assign cfg_ready = 1'b1;

	// Configuration write transactions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_score_q <= MIN_SCORE_RESET;
			max_score_q <= MAX_SCORE_RESET;
			score_inc_q <= INC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_SCORE: min_score_q <= signed'(cfg_data);
				CFG_MAX_SCORE: max_score_q <= signed'(cfg_data);
				CFG_SCORE_INC: score_inc_q <= cfg_data[INC_W-1:0];
				default:       ;
			endcase
		end
	end

	// Offset from the lowest half interval and the range checks.
	always_comb begin
		inc_eff     = (score_inc_q == '0) ? INC_W'(1) : score_inc_q;
		two_inc     = {inc_eff, 1'b0};
		x_ext       = 27'(x_q);
		d_val       = ((x_ext - 27'(min_score_q)) <<< 1) + signed'(27'(inc_eff));
		two_x       = x_ext <<< 1;
		hundred_lim = (27'(max_score_q) <<< 1) + signed'(27'(inc_eff));
		below       = d_val[26];
		above       = (d_val[25:0] >= 26'(two_inc)) && (two_x >= hundred_lim);
		clamp_c     = {1'b0, div_quot} >= 27'(TABLE_DEPTH);
	end

	// Shared multiplier.
	assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_b);
	// Times 100 as 64 + 32 + 4.
	assign scaled = {num_q, 6'b0} + {1'b0, num_q, 5'b0} + {4'b0, num_q, 2'b0};

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (accept && operation == OP_QUERY) state_nxt = ST_PREP;
			ST_PREP:  state_nxt = (below || above) ? ST_DONE : ST_DIV1;
			ST_DIV1:  if (div_stat.last) state_nxt = ST_RD_HI;
			ST_RD_HI: state_nxt = ST_RD_LO;
			ST_RD_LO: state_nxt = ST_CAP;
			ST_CAP:   state_nxt = ST_MUL_A;
			ST_MUL_A: state_nxt = ST_MUL_B;
			ST_MUL_B: state_nxt = ST_SUM;
			ST_SUM:   state_nxt = ST_SCALE;
			ST_SCALE: state_nxt = ST_DIV2;
			ST_DIV2:  if (div_stat.last) state_nxt = ST_DONE;
			ST_DONE:  state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy          = (state_q != ST_IDLE);
		done          = 1'b0;
		div_cmd.start = 1'b0;
		div_cmd.steps = DIV1_STEPS;
		div_init_rem  = '0;
		div_init_low  = d_val[DIV_Q_W-1:0];
		rd_addr       = div_quot[IDX_W-1:0];
		mul_a         = lo_q;
		mul_b         = two_inc - r_q;
		case (state_q)
			ST_PREP: begin
				div_cmd.start = !(below || above);
			end
			ST_RD_HI: begin
				rd_addr = clamp_c ? IDX_W'(TABLE_DEPTH - 1) : div_quot[IDX_W-1:0];
			end
			ST_RD_LO: begin
				rd_addr = clamp_q ? IDX_W'(TABLE_DEPTH - 1)
					: div_quot[IDX_W-1:0] - IDX_W'(1);
			end
			ST_MUL_B: begin
				mul_a = hi_q;
				mul_b = r_q;
			end
			ST_SCALE: begin
				div_cmd.start = 1'b1;
				div_cmd.steps = DIV2_STEPS;
				div_init_rem  = scaled[46:23];
				div_init_low  = {scaled[22:0], 3'b0};
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: ;
		endcase
	end

	assign percentile_rank = use_div_q ? div_quot[RANK_W-1:0] : rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Query datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= query_score;
			end
			ST_PREP: begin
				use_div_q <= !(below || above);
				rank_q    <= below ? '0 : RANK_MAX;
			end
			ST_RD_HI: begin
				clamp_q <= clamp_c;
				r_q     <= clamp_c ? '0 : div_rem;
			end
			ST_RD_LO: begin
				hi_q <= rd_data;
			end
			ST_CAP: begin
				lo_q <= (div_quot == '0 && !clamp_q) ? '0 : rd_data;
			end
			ST_MUL_A: begin
				prod_q <= mul_p;
			end
			ST_MUL_B: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_SUM: begin
				num_q <= acc_q + prod_q;
			end
			default: ;
		endcase
	end

	prf_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.init_rem (div_init_rem),
		.init_low (div_init_low),
		.divisor  (two_inc),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	prf_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_en     (load_en),
		.entry_index (entry_index),
		.freq_value  (freq_value),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_QUERY |=> busy)
		else $error("query accepted without going busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_en |=> !busy)
		else $error("load transaction made the block busy");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_cmd.start |-> !div_stat.busy)
		else $error("divider started while still running");

endmodule

/* tb/sv/tb_percentile_rank_from_frequencies.sv */
`timescale 1ns / 100ps

module tb_percentile_rank_from_frequencies;
	import prf_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEFAULT;
	localparam int IDLE_PCT = 23;
	localparam int SETTLE_CYCLES = 70;
	localparam int STALL_LIMIT = 2000;

	// Register index with no register behind it.
	localparam logic [CFG_IX_W-1:0] CFG_UNUSED = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       operation;
	logic [INDEX_W-1:0]         entry_index;
	logic [FREQ_W-1:0]          freq_value;
	logic signed [SCORE_W-1:0]  query_score;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IX_W-1:0]        cfg_index;
	logic [SCORE_W-1:0]         cfg_data;
	logic                       done;
	logic [RANK_W-1:0]          percentile_rank;

	// Tracks the score scale, the cumulative frequency table and the ranks still owed.
	class rank_scoreboard;
		logic signed [SCORE_W-1:0] lo_score;
		logic signed [SCORE_W-1:0] hi_score;
		logic [INC_W-1:0]          step;
		logic [FREQ_W-1:0]         run_sum;
		logic [FREQ_W-1:0]         cum [DEPTH];
		bit                        loaded [DEPTH];
		logic [RANK_W-1:0]         expected_ranks [$];
		int                        mismatches;

		function new();
			lo_score = MIN_SCORE_RESET;
			hi_score = MAX_SCORE_RESET;
			step = INC_RESET;
			run_sum = '0;
			mismatches = 0;
			foreach (loaded[k]) begin
				loaded[k] = 1'b0;
				cum[k] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IX_W-1:0] ix, logic [SCORE_W-1:0] data);
			case (ix)
				CFG_MIN_SCORE: lo_score = data;
				CFG_MAX_SCORE: hi_score = data;
				CFG_SCORE_INC: step = data[INC_W-1:0];
				default: ;
			endcase
		endfunction

		// Rank of a score under the present table; blind is set when an unloaded
		// entry would be read.
		function logic [RANK_W-1:0] rank_for(logic signed [SCORE_W-1:0] score,
				output bit blind);
			longint xs, mn, mx, inc, two, d, i, r, lo, hi, num, val;
			xs = score;
			mn = lo_score;
			mx = hi_score;
			inc = step;
			blind = 1'b0;
			if (inc == 0)
				inc = 1;
			two = 2 * inc;
			d = 2 * (xs - mn) + inc;
			if (d < 0)
				return '0;
			if (d >= two && 2 * xs >= 2 * mx + inc)
				return RANK_MAX;
			i = d / two;
			if (i >= DEPTH) begin
				blind = !loaded[DEPTH-1];
				val = 100 * longint'(cum[DEPTH-1]);
			end else begin
				r = d - i * two;
				lo = 0;
				if (i > 0) begin
					lo = cum[i-1];
					blind = !loaded[i-1];
				end
				hi = cum[i];
				if (!loaded[i])
					blind = 1'b1;
				num = lo * two + r * (hi - lo);
				if (num < 0)
					num = 0;
				val = (100 * num) / two;
			end
			if (val > longint'(RANK_MAX))
				val = RANK_MAX;
			return val[RANK_W-1:0];
		endfunction

		// Applies one accepted transaction: a load updates the table, a query owes a rank.
		function void note_item(logic op, logic [INDEX_W-1:0] ix, logic [FREQ_W-1:0] fq,
				logic signed [SCORE_W-1:0] sc);
			logic [FREQ_W:0] total;
			bit blind;
			if (op == OP_LOAD) begin
				total = (ix == 0) ? {1'b0, fq} : run_sum + fq;
				if (total > FREQ_ONE)
					total = FREQ_ONE;
				run_sum = total[FREQ_W-1:0];
				cum[ix] = run_sum;
				loaded[ix] = 1'b1;
			end else begin
				expected_ranks.push_back(rank_for(sc, blind));
			end
		endfunction

		task report_mismatch(string what);
			$display("[%0t] rank check: %s", $time, what);
			mismatches++;
		endtask

		task check_rank(logic [RANK_W-1:0] got);
			logic [RANK_W-1:0] want;
			if (expected_ranks.size() == 0) begin
				report_mismatch($sformatf("rank %0d with no query outstanding", got));
				return;
			end
			want = expected_ranks.pop_front();
			if (got !== want)
				report_mismatch($sformatf("got rank %0d, expected %0d", got, want));
		endtask
	endclass

	rank_scoreboard sb;
	bit             idle_on;
	int             table_len;
	int             stall_count;

	percentile_rank_from_frequencies u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.entry_index     (entry_index),
		.freq_value      (freq_value),
		.query_score     (query_score),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.percentile_rank (percentile_rank)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Every done strobe is one result transaction.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_rank(percentile_rank);
	end

	// Ends the run when nothing has been accepted for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_count <= 0;
		else if (stall_count >= STALL_LIMIT) begin
			$display("percentile_rank_from_frequencies: mismatch");
			$finish;
		end else
			stall_count <= stall_count + 1;
	end

	function automatic logic [SCORE_W-1:0] clamp_score(longint v);
		if (v < -8388608)
			v = -8388608;
		if (v > 8388607)
			v = 8388607;
		return v[SCORE_W-1:0];
	endfunction

	// Random idle cycles ahead of a transaction, while idling is enabled.
	task automatic idle_gap();
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			start = 1'b0;
			cfg_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	// Presents one item and returns at the edge that accepts it.
	task automatic send_item(logic op, logic [INDEX_W-1:0] ix, logic [FREQ_W-1:0] fq,
			logic signed [SCORE_W-1:0] sc);
		@(negedge clk);
		idle_gap();
		start = 1'b1;
		operation = op;
		entry_index = ix;
		freq_value = fq;
		query_score = sc;
		do @(posedge clk); while (busy);
		sb.note_item(op, ix, fq, sc);
	endtask

	task automatic send_load(logic [INDEX_W-1:0] ix, logic [FREQ_W-1:0] fq);
		send_item(OP_LOAD, ix, fq, SCORE_W'($urandom));
	endtask

	task automatic send_query(logic signed [SCORE_W-1:0] sc);
		send_item(OP_QUERY, INDEX_W'($urandom), FREQ_W'($urandom), sc);
	endtask

	task automatic stop_items();
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IX_W-1:0] ix, logic [SCORE_W-1:0] data);
		@(negedge clk);
		idle_gap();
		cfg_valid = 1'b1;
		cfg_index = ix;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(ix, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers change only once every owed rank has come and the block has settled.
	task automatic set_scale(logic [SCORE_W-1:0] mn, logic [SCORE_W-1:0] mx,
			logic [SCORE_W-1:0] inc);
		stop_items();
		while (sb.expected_ranks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_MIN_SCORE, mn);
		write_reg(CFG_MAX_SCORE, mx);
		write_reg(CFG_SCORE_INC, inc);
	endtask

	// Picks a score near the loaded intervals, or anywhere, that reads only loaded entries.
	task automatic choose_score(output logic signed [SCORE_W-1:0] sc, output bit ok);
		longint inc, mn, x;
		bit blind;
		ok = 1'b0;
		sc = '0;
		mn = sb.lo_score;
		inc = sb.step;
		if (inc == 0)
			inc = 1;
		for (int t = 0; t < 40 && !ok; t++) begin
			if ($urandom_range(99) < 75) begin
				x = mn + (longint'($urandom_range(table_len + 1)) - 1) * inc - inc / 2;
				if ($urandom_range(99) >= 20)
					x = x + $urandom_range(32'(inc - 1));
				sc = clamp_score(x);
			end else begin
				sc = SCORE_W'($urandom);
			end
			void'(sb.rank_for(sc, blind));
			ok = !blind;
		end
	endtask

	task automatic random_scale();
		longint mn, mx, inc;
		case ($urandom_range(3))
			0: begin
				mn = longint'($urandom_range(4000)) - 2000;
				inc = $urandom_range(1, 512);
				mx = mn + inc * $urandom_range(0, 70);
			end
			1: begin
				mn = longint'($urandom_range(16777215)) - 8388608;
				inc = $urandom_range(1, 16);
				mx = mn + inc * $urandom_range(0, 1100);
			end
			2: begin
				mn = longint'($urandom_range(16777215)) - 8388608;
				mx = longint'($urandom_range(16777215)) - 8388608;
				inc = $urandom_range(8388607);
			end
			default: begin
				mn = longint'($urandom_range(2000)) - 1000;
				inc = 0;
				mx = mn + $urandom_range(0, 1200);
			end
		endcase
		set_scale(clamp_score(mn), clamp_score(mx), inc[SCORE_W-1:0]);
	endtask

	// Mostly table loads in index order followed by queries, with stray loads and queries mixed in.
	task automatic random_phase(int count);
		int sent, pick, n, share, q;
		logic signed [SCORE_W-1:0] sc;
		bit ok;
		logic [FREQ_W-1:0] fq;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				n = $urandom_range(1, 64);
				share = (2 * 65536) / n;
				for (int k = 0; k < n; k++) begin
					fq = FREQ_W'($urandom_range(share));
					if ($urandom_range(99) < 3)
						fq = FREQ_W'($urandom_range(131071));
					send_load(INDEX_W'(k), fq);
				end
				if (n > table_len)
					table_len = n;
				sent += n;
				q = $urandom_range(1, 5);
				for (int k = 0; k < q; k++) begin
					choose_score(sc, ok);
					if (ok)
						send_query(sc);
				end
				sent += q;
			end else if (pick < 52) begin
				send_load(INDEX_W'($urandom_range(1023)), FREQ_W'($urandom_range(131071)));
				sent++;
			end else begin
				choose_score(sc, ok);
				if (ok)
					send_query(sc);
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		idle_on = 1'b1;
		table_len = 0;
		stall_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_LOAD;
		entry_index = '0;
		freq_value = '0;
		query_score = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MIN_SCORE;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default scale; a write to the unused register index is ignored.
		set_scale(24'd0, 24'd10240, 24'd256);
		write_reg(CFG_UNUSED, 24'hA5A5A5);
		send_load(0, 17'd0);
		send_load(1, 17'd65536);
		send_load(2, 17'h1FFFF);
		send_load(1023, 17'd40000);
		send_load(0, 17'd1000);
		send_load(1, 17'd20000);
		send_load(2, 17'd30000);
		send_load(3, 17'd20000);
		send_load(4, 17'd40000);
		table_len = 5;
		send_query(-24'sd8388608);
		send_query(24'sd8388607);
		send_query(-24'sd129);
		send_query(-24'sd128);
		send_query(24'sd0);
		send_query(24'sd300);
		send_query(24'sd1000);

		// Top of the range falls inside the loaded entries.
		set_scale(24'd0, 24'd1024, 24'd256);
		send_query(24'sd1151);
		send_query(24'sd1152);

		// Zero increment, widest range: the interval runs past the end of the table.
		set_scale(24'h800000, 24'h7FFFFF, 24'd0);
		send_query(-24'sd8388608);
		send_query(-24'sd8386608);

		// Inverted range with the largest increment.
		set_scale(24'd5000, -24'sd5000, 24'hFFFFFF);
		send_query(24'sd5000);
		send_query(-24'sd8388608);
		send_query(24'sd8388607);

		for (int p = 0; p < 8; p++) begin
			random_scale();
			idle_on = (p != 3);
			random_phase(72);
		end

		stop_items();
		while (sb.expected_ranks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("percentile_rank_from_frequencies: match");
		else
			$display("percentile_rank_from_frequencies: mismatch");
		$finish;
	end

endmodule

/* percentile_rank_from_frequencies.f */
rtl/prf_pkg.sv
rtl/prf_divider.sv
rtl/prf_table.sv
rtl/percentile_rank_from_frequencies.sv
tb/sv/tb_percentile_rank_from_frequencies.sv
